@@ hw/rtl/i2cts_pkg.sv @@
// Package for the I2C transaction scheduler: beat payload types, phase,
// status and start codes, controller command and status structs.
// No dependencies.
package i2cts_pkg;

    localparam int NUM_PORTS_DEF = 16;
    localparam int MAX_LEN       = 255;
    localparam int PORT_W        = 4;
    localparam int LEN_W         = 8;
    localparam int ADDR_W        = 7;
    localparam int SPEED_W       = 2;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_WRITE = 3'd1;
    localparam logic [2:0] PH_READ  = 3'd2;
    localparam logic [2:0] PH_STOP  = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    localparam logic [1:0] ST_BUSY  = 2'd0;
    localparam logic [1:0] ST_OK    = 2'd1;
    localparam logic [1:0] ST_WNACK = 2'd2;
    localparam logic [1:0] ST_RNACK = 2'd3;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_STOP  = 2'd2;

    typedef struct packed {
        logic               add_valid;
        logic [PORT_W-1:0]  port;
        logic [LEN_W-1:0]   tx_len;
        logic [LEN_W-1:0]   rx_len;
        logic [ADDR_W-1:0]  slave_addr;
        logic [SPEED_W-1:0] bus_speed;
        logic               bus_busy;
        logic               stop_seen;
        logic               access_ready;
        logic               nack_seen;
        logic               master_active;
        logic               dma_done;
    } in_beat_t;

    typedef struct packed {
        logic               start_valid;
        logic [PORT_W-1:0]  start_port;
        logic [1:0]         start_kind;
        logic [ADDR_W-1:0]  start_addr;
        logic [SPEED_W-1:0] start_speed;
        logic [LEN_W-1:0]   start_count;
        logic               query_done;
        logic [1:0]         query_status;
    } out_beat_t;

    // Stored transaction row
    typedef struct packed {
        logic [LEN_W-1:0]   wlen;
        logic [LEN_W-1:0]   rlen;
        logic [ADDR_W-1:0]  addr;
        logic [SPEED_W-1:0] speed;
    } row_t;

    typedef struct packed {
        logic ready;
        logic accept;
        logic finish;
        logic pick;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_stat_t;

    function automatic logic running(input logic [2:0] ph);
        return (ph == PH_WRITE) || (ph == PH_READ) || (ph == PH_STOP);
    endfunction

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
        return (32'(v) > MAX_LEN) ? LEN_W'(MAX_LEN) : v;
    endfunction

endpackage

@@ hw/rtl/i2cts_in_if.sv @@
// Input channel of the I2C transaction scheduler: valid, ready and beat.
// Depends on i2cts_pkg.
interface i2cts_in_if;
    import i2cts_pkg::*;

    logic     valid;
    logic     ready;
    in_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/i2cts_out_if.sv @@
// Result channel of the I2C transaction scheduler: valid, ready and beat.
// Depends on i2cts_pkg.
interface i2cts_out_if;
    import i2cts_pkg::*;

    logic      valid;
    logic      ready;
    out_beat_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/i2cts_ctrl.sv @@
// Sequencer of the I2C transaction scheduler: accept, finish, pick, emit.
// Depends on i2cts_pkg.
module i2cts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  i2cts_pkg::dp_stat_t   stat,
    output i2cts_pkg::ctrl_cmd_t  cmd
);
    import i2cts_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_FINISH = 2'd1;
    localparam logic [1:0] S_PICK   = 2'd2;
    localparam logic [1:0] S_EMIT   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready  = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = S_PICK;
            end
            S_PICK:
            begin
                cmd.pick   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the result register is free
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hw/rtl/i2cts_dp.sv @@
// Datapath of the I2C transaction scheduler: per-port phase and status
// registers, transaction row memory, active tracking, result register.
// Depends on i2cts_pkg.
module i2cts_dp #(
    parameter int NUM_PORTS = i2cts_pkg::NUM_PORTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  i2cts_pkg::ctrl_cmd_t  cmd,
    output i2cts_pkg::dp_stat_t   stat,
    input  i2cts_pkg::in_beat_t   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output i2cts_pkg::out_beat_t  out_data
);
    import i2cts_pkg::*;

    localparam int IDX_W = $clog2(NUM_PORTS);

    logic [2:0]       phase_reg [NUM_PORTS];
    logic [1:0]       status_reg [NUM_PORTS];
    row_t             mem [NUM_PORTS];
    row_t             rd_row_reg;
    in_beat_t         item_reg;
    logic             active_valid_reg;
    logic [IDX_W-1:0] active_port_reg;
    logic [LEN_W-1:0] active_rlen_reg;
    logic             start_vld_reg;
    logic [IDX_W-1:0] start_port_reg;
    logic [2:0]       start_ph_reg;
    logic             out_valid_reg;
    out_beat_t        out_reg;

    logic             in_port_ok;
    logic [IDX_W-1:0] in_idx;
    logic             q_port_ok;
    logic [IDX_W-1:0] q_idx;
    logic             do_add;
    row_t             add_row;
    logic [2:0]       act_ph;
    logic             fin;
    logic             found;
    logic [IDX_W-1:0] pick_idx;
    out_beat_t        res;

    assign in_port_ok = 32'(in_data.port) < NUM_PORTS;
    assign in_idx     = IDX_W'(in_data.port);
    assign q_port_ok  = 32'(item_reg.port) < NUM_PORTS;
    assign q_idx      = IDX_W'(item_reg.port);
    assign do_add     = cmd.accept && in_data.add_valid && in_port_ok;

    assign add_row.wlen  = clamp_len(in_data.tx_len);
    assign add_row.rlen  = clamp_len(in_data.rx_len);
    assign add_row.addr  = in_data.slave_addr;
    assign add_row.speed = in_data.bus_speed;

    // Finish check of the active phase against the latched bus flags
    assign act_ph = phase_reg[active_port_reg];
    always_comb
    begin
        if (act_ph == PH_STOP)
        begin
            fin = !item_reg.bus_busy && item_reg.stop_seen;
        end
        else if (item_reg.access_ready && item_reg.nack_seen)
        begin
            fin = 1'b1;
        end
        else if (act_ph == PH_WRITE)
        begin
            fin = !item_reg.bus_busy && !item_reg.master_active && item_reg.dma_done;
        end
        else
        begin
            fin = !item_reg.bus_busy && item_reg.stop_seen && item_reg.dma_done;
        end
    end

    // Lowest running port
    always_comb
    begin
        found    = 1'b0;
        pick_idx = '0;
        for (int i = NUM_PORTS - 1; i >= 0; i--)
        begin
            if (running(phase_reg[i]))
            begin
                found    = 1'b1;
                pick_idx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PORTS; i++)
            begin
                phase_reg[i]  <= PH_IDLE;
                status_reg[i] <= ST_BUSY;
            end
            active_valid_reg <= 1'b0;
            active_port_reg  <= '0;
            start_vld_reg    <= 1'b0;
        end
        else
        begin
            if (do_add)
            begin
                phase_reg[in_idx]  <= (add_row.wlen != '0) ? PH_WRITE : PH_READ;
                status_reg[in_idx] <= ST_BUSY;
            end
            if (cmd.finish && active_valid_reg)
            begin
                if (!running(act_ph))
                begin
                    active_valid_reg <= 1'b0;
                end
                else if (fin)
                begin
                    active_valid_reg <= 1'b0;
                    case (act_ph)
                        PH_WRITE:
                        begin
                            if (item_reg.nack_seen)
                            begin
                                status_reg[active_port_reg] <= ST_WNACK;
                                phase_reg[active_port_reg]  <= PH_STOP;
                            end
                            else if (active_rlen_reg != '0)
                            begin
                                phase_reg[active_port_reg] <= PH_READ;
                            end
                            else
                            begin
                                phase_reg[active_port_reg]  <= PH_DONE;
                                status_reg[active_port_reg] <= ST_OK;
                            end
                        end
                        PH_READ:
                        begin
                            if (item_reg.nack_seen)
                            begin
                                status_reg[active_port_reg] <= ST_RNACK;
                                phase_reg[active_port_reg]  <= PH_STOP;
                            end
                            else
                            begin
                                phase_reg[active_port_reg]  <= PH_DONE;
                                status_reg[active_port_reg] <= ST_OK;
                            end
                        end
                        default:
                        begin
                            phase_reg[active_port_reg] <= PH_DONE;
                        end
                    endcase
                end
            end
            if (cmd.pick)
            begin
                start_vld_reg <= found && !active_valid_reg;
                if (found && !active_valid_reg)
                begin
                    active_valid_reg <= 1'b1;
                    active_port_reg  <= pick_idx;
                end
            end
        end
    end

    // Payload registers: item latch, start capture, active read length
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            item_reg <= in_data;
        end
        if (cmd.pick)
        begin
            start_port_reg <= pick_idx;
            start_ph_reg   <= phase_reg[pick_idx];
        end
        if (do_add && active_valid_reg && in_idx == active_port_reg)
        begin
            active_rlen_reg <= add_row.rlen;
        end
        else if (cmd.emit && start_vld_reg)
        begin
            active_rlen_reg <= rd_row_reg.rlen;
        end
    end

    // Transaction row memory: write on add, registered read at the pick
    always_ff @(posedge clk)
    begin
        if (do_add)
        begin
            mem[in_idx] <= add_row;
        end
        if (cmd.pick)
        begin
            rd_row_reg <= mem[pick_idx];
        end
    end

    always_comb
    begin
        res = '0;
        if (start_vld_reg)
        begin
            res.start_valid = 1'b1;
            res.start_port  = PORT_W'(start_port_reg);
            case (start_ph_reg)
                PH_STOP:
                begin
                    res.start_kind = KIND_STOP;
                end
                PH_WRITE:
                begin
                    res.start_kind  = KIND_WRITE;
                    res.start_addr  = rd_row_reg.addr;
                    res.start_speed = rd_row_reg.speed;
                    res.start_count = rd_row_reg.wlen;
                end
                default:
                begin
                    res.start_kind  = KIND_READ;
                    res.start_addr  = rd_row_reg.addr;
                    res.start_speed = rd_row_reg.speed;
                    res.start_count = rd_row_reg.rlen;
                end
            endcase
        end
        if (q_port_ok && phase_reg[q_idx] != PH_IDLE)
        begin
            res.query_done   = (phase_reg[q_idx] == PH_DONE);
            res.query_status = status_reg[q_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg <= res;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;

    // An active port always sits in a running phase
    a_active_running: assert property (@(posedge clk) disable iff (!rst_n)
        active_valid_reg |-> running(phase_reg[active_port_reg]))
        else $error("active port not in a running phase");

    // A pick with a pending port and nothing active starts that port
    a_pick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pick && found && !active_valid_reg) |=> (active_valid_reg && start_vld_reg))
        else $error("pending port not started");

    // A result beat is loaded only into a free result register
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten");

endmodule

@@ hw/rtl/i2c_transaction_scheduler_top.sv @@
// Top level of the I2C transaction scheduler: sequencer plus datapath.
// Depends on i2cts_pkg, i2cts_in_if, i2cts_out_if, i2cts_ctrl, i2cts_dp.
// Order: after the edge that takes an input beat, the sequencer runs finish,
//   pick and emit, and emit waits while the last result is still held.
// Input beats: a new beat is taken only after the last has passed the
//   sequencer's finish, pick and emit steps and the row memory's registered read.
// Reset: all ports idle with status busy, nothing active, result empty;
//   the transaction row memory is not cleared and needs no clearing pass.
module i2c_transaction_scheduler_top #(
    parameter int NUM_PORTS = i2cts_pkg::NUM_PORTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    i2cts_in_if.sink    item,
    i2cts_out_if.source result
);
    import i2cts_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // Sequence each beat: take it and apply any add, then check the active
    // phase, then pick the lowest pending port, then load the result.
    i2cts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .stat     (stat),
        .cmd      (cmd)
    );

    assign item.ready = cmd.ready;

    // Result register lets a new beat be taken while the last result waits.
    i2cts_dp #(
        .NUM_PORTS (NUM_PORTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (item.data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (result.data)
    );

endmodule
